FILE: hw/rtl/erpd_pkg.sv
// Shared types and constants for the epoch reset packet decoder.
package erpd_pkg;

    localparam int unsigned PACKET_BYTES_DEF = 32;
    localparam int unsigned MAGIC_W          = 32;
    localparam int unsigned COUNT_W          = 16;
    localparam int unsigned WORD_W           = 64;
    localparam int unsigned HALF_W           = 16;

    localparam logic [MAGIC_W-1:0] MAGIC_RESET = 32'h5244_3650;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;
    localparam logic [HALF_W-1:0]  VERSION_ONE = 16'd1;

    // Verdict codes, in the order the checks are made.
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SIZE       = 3'd1,
        ST_MAGIC      = 3'd2,
        ST_VERSION    = 3'd3,
        ST_LENGTH     = 3'd4,
        ST_TRANSITION = 3'd5
    } t_status;

    // Packet header state as collected so far.
    typedef struct packed {
        logic [COUNT_W-1:0] byte_count;
        logic               magic_ok;
        logic [HALF_W-1:0]  version_word;
        logic [HALF_W-1:0]  length_word;
        logic [WORD_W-1:0]  session_word;
        logic [WORD_W-1:0]  previous_word;
        logic [WORD_W-1:0]  next_word;
    } t_pkt;

    // One verdict.
    typedef struct packed {
        logic              accepted;
        t_status           status;
        logic [WORD_W-1:0] session_id;
        logic [WORD_W-1:0] previous_epoch;
        logic [WORD_W-1:0] next_epoch;
    } t_result;

endpackage

FILE: hw/rtl/erpd_in_if.sv
// Byte channel into the decoder: valid, ready and one packet byte.
interface erpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

FILE: hw/rtl/erpd_out_if.sv
// Verdict channel out of the decoder: valid, ready and one verdict.
interface erpd_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [2:0]  status;
    logic [63:0] session_id;
    logic [63:0] previous_epoch;
    logic [63:0] next_epoch;

    modport source (
        output valid, output accepted, output status,
        output session_id, output previous_epoch, output next_epoch,
        input  ready
    );
    modport sink (
        input  valid, input accepted, input status,
        input  session_id, input previous_epoch, input next_epoch,
        output ready
    );
endinterface

FILE: hw/rtl/epoch_reset_packet_decoder_core.sv
// Top level of the epoch reset packet decoder: input register, collector and verdict.
//
//   channel   direction  handshake          word
//   i_in      in         valid / ready      byte_value[7:0], last_byte
//   o_out     out        valid / ready      accepted, status[2:0], session_id,
//                                           previous_epoch, next_epoch (64 each)
//   cfg       in         i_cfg_we           i_cfg_wdata[31:0] = packet magic
//
// One byte is taken every cycle while no final byte waits in the input register
// for room in the result register. A byte is held in the input register, and the
// verdict for a final byte is loaded at the edge where that byte leaves the
// register. Throughput is set by the single pass from the input register through
// the header collector to the result register: one byte per clock when unstalled.
// Reset (i_rst_n low, synchronous) empties both registers and restores the
// packet magic. A stalled verdict holds the input register only when it holds
// a final byte; other bytes keep flowing into the collector.
module epoch_reset_packet_decoder_core #(
    parameter int unsigned PACKET_BYTES = erpd_pkg::PACKET_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    erpd_in_if.sink                      i_in,
    erpd_out_if.source                   o_out,
    input  logic                         i_cfg_we,
    input  logic [erpd_pkg::MAGIC_W-1:0] i_cfg_wdata
);
    import erpd_pkg::*;

    // Input register: one byte with its end-of-packet mark.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    logic    out_valid;
    logic    out_free;
    logic    fire;
    t_pkt    fields;
    t_result result;

    // The result slot is free when empty or being emptied this cycle.
    assign out_free = !out_valid || o_out.ready;

    // A byte leaves the input register when it is not a final byte, or when
    // the verdict it produces has room in the result register.
    assign fire       = r_in_valid && (!r_in_last || out_free);
    assign i_in.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.byte_value;
            r_in_last <= i_in.last_byte;
        end
    end

    erpd_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (fire),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .o_fields    (fields)
    );

    erpd_verdict #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_verdict (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire && r_in_last),
        .i_ready  (o_out.ready),
        .i_fields (fields),
        .o_valid  (out_valid),
        .o_result (result)
    );

    assign o_out.valid          = out_valid;
    assign o_out.accepted       = result.accepted;
    assign o_out.status         = result.status;
    assign o_out.session_id     = result.session_id;
    assign o_out.previous_epoch = result.previous_epoch;
    assign o_out.next_epoch     = result.next_epoch;

`ifndef SYNTHESIS
    // Bytes that are not final never wait.
    a_body_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !r_in_last |-> fire)
        else $error("non-final byte stalled in input register");

    // The accepted flag agrees with the status code.
    a_accept_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (o_out.accepted == (o_out.status == ST_OK)))
        else $error("accepted flag disagrees with status");

    // A rejected packet carries zero fields.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !o_out.accepted |->
            (o_out.session_id == '0 && o_out.previous_epoch == '0 &&
             o_out.next_epoch == '0))
        else $error("rejected verdict has nonzero fields");

    // A final byte produces a verdict in the next cycle.
    a_final_gives_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in_last |=> out_valid)
        else $error("final byte did not produce a verdict");
`endif

endmodule

FILE: hw/rtl/erpd_accum.sv
// Header collector: magic register, byte counter and the packet fields.
module erpd_accum (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [erpd_pkg::MAGIC_W-1:0]  i_cfg_wdata,
    input  logic                          i_take,
    input  logic [7:0]                    i_byte,
    input  logic                          i_last,
    output erpd_pkg::t_pkt                o_fields
);
    import erpd_pkg::*;

    logic [MAGIC_W-1:0] r_magic;
    t_pkt               r_pkt;
    t_pkt               n_pkt;
    t_pkt               pkt_clear;
    logic [COUNT_W-1:0] pos;

    always_comb begin
        pkt_clear               = '0;
        pkt_clear.magic_ok      = 1'b1;
    end

    // Next header state with the current byte merged in.
    always_comb begin
        n_pkt = r_pkt;
        pos   = r_pkt.byte_count;
        if (pos < 16'd4) begin
            if (i_byte != r_magic[{pos[1:0], 3'b000} +: 8]) begin
                n_pkt.magic_ok = 1'b0;
            end
        end else if (pos < 16'd6) begin
            n_pkt.version_word[{pos[0], 3'b000} +: 8] = i_byte;
        end else if (pos < 16'd8) begin
            n_pkt.length_word[{pos[0], 3'b000} +: 8] = i_byte;
        end else if (pos < 16'd16) begin
            n_pkt.session_word[{pos[2:0], 3'b000} +: 8] = i_byte;
        end else if (pos < 16'd24) begin
            n_pkt.previous_word[{pos[2:0], 3'b000} +: 8] = i_byte;
        end else if (pos < 16'd32) begin
            n_pkt.next_word[{pos[2:0], 3'b000} +: 8] = i_byte;
        end
        if (pos != COUNT_MAX) begin
            n_pkt.byte_count = pos + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= MAGIC_RESET;
            r_pkt   <= pkt_clear;
        end else begin
            if (i_cfg_we) begin
                r_magic <= i_cfg_wdata;
            end
            if (i_take) begin
                r_pkt <= i_last ? pkt_clear : n_pkt;
            end
        end
    end

    assign o_fields = n_pkt;

endmodule

FILE: hw/rtl/erpd_verdict.sv
// Verdict checks and the result register with its valid flag.
module erpd_verdict #(
    parameter int unsigned PACKET_BYTES = erpd_pkg::PACKET_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_ready,
    input  erpd_pkg::t_pkt    i_fields,
    output logic              o_valid,
    output erpd_pkg::t_result o_result
);
    import erpd_pkg::*;

    localparam logic [COUNT_W-1:0] SIZE_WANT = COUNT_W'(PACKET_BYTES);

    t_status status;
    t_result n_result;
    t_result r_result;
    logic    r_valid;

    always_comb begin
        if (i_fields.byte_count != SIZE_WANT) begin
            status = ST_SIZE;
        end else if (!i_fields.magic_ok) begin
            status = ST_MAGIC;
        end else if (i_fields.version_word != VERSION_ONE) begin
            status = ST_VERSION;
        end else if (i_fields.length_word != SIZE_WANT) begin
            status = ST_LENGTH;
        end else if (i_fields.session_word == '0 || i_fields.previous_word == '0 ||
                     i_fields.next_word <= i_fields.previous_word) begin
            status = ST_TRANSITION;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        n_result                = '0;
        n_result.status         = status;
        n_result.accepted       = (status == ST_OK);
        if (status == ST_OK) begin
            n_result.session_id     = i_fields.session_word;
            n_result.previous_epoch = i_fields.previous_word;
            n_result.next_epoch     = i_fields.next_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: tb/sv/epoch_reset_packet_decoder_core_test.sv
// Self-checking testbench for the epoch reset packet decoder core.
module epoch_reset_packet_decoder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import erpd_pkg::*;

    // Packet size used for this build of the block.
    localparam int PKT_LEN = 32;
    // A byte is held in the input register and the verdict follows in the result
    // register; the extra drain cycles cover any byte still in flight.
    localparam int DRAIN_CYCLES = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    erpd_in_if  in_if ();
    erpd_out_if out_if ();

    epoch_reset_packet_decoder_core #(
        .PACKET_BYTES(PKT_LEN)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    // Idling in percent of cycles for the byte sender and the verdict receiver.
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;

    int unsigned error_count;
    int unsigned bytes_sent;
    int unsigned verdicts_seen;

    // Verdicts predicted for packets whose final byte has been taken, oldest first.
    t_result pending_verdicts[$];

    // Bytes of the packet about to be sent.
    logic [7:0] pkt_bytes[$];

    // Predictor copy of the magic register and of the per-packet header state.
    logic [31:0] magic_reg;
    logic [15:0] pkt_count;
    logic        pkt_magic_ok;
    logic [15:0] pkt_version;
    logic [15:0] pkt_length;
    logic [63:0] pkt_session;
    logic [63:0] pkt_previous;
    logic [63:0] pkt_next;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #200_000;
        $display("simulation failed");
        $finish;
    end

    // Start a fresh packet in the predictor; the magic register is kept.
    function automatic void clear_packet();
        pkt_count    = '0;
        pkt_magic_ok = 1'b1;
        pkt_version  = '0;
        pkt_length   = '0;
        pkt_session  = '0;
        pkt_previous = '0;
        pkt_next     = '0;
    endfunction

    // Fold one accepted byte into the header state. On a final byte the verdict
    // is worked out and queued, and the header state starts over.
    function automatic void track_byte(input logic [7:0] b, input logic last);
        t_result verdict;
        t_status st;
        int      pos;
        pos = pkt_count;
        if (pos < PKT_LEN) begin
            if (pos < 4) begin
                if (b != magic_reg[8*pos +: 8]) pkt_magic_ok = 1'b0;
            end else if (pos < 6) begin
                pkt_version[8*(pos-4) +: 8] = b;
            end else if (pos < 8) begin
                pkt_length[8*(pos-6) +: 8] = b;
            end else if (pos < 16) begin
                pkt_session[8*(pos-8) +: 8] = b;
            end else if (pos < 24) begin
                pkt_previous[8*(pos-16) +: 8] = b;
            end else if (pos < 32) begin
                pkt_next[8*(pos-24) +: 8] = b;
            end
        end
        if (pkt_count != COUNT_MAX) pkt_count = pkt_count + 16'd1;
        if (last) begin
            // The first failing check, in this order, decides the verdict.
            if (pkt_count != PKT_LEN) st = ST_SIZE;
            else if (!pkt_magic_ok) st = ST_MAGIC;
            else if (pkt_version != VERSION_ONE) st = ST_VERSION;
            else if (pkt_length != PKT_LEN) st = ST_LENGTH;
            else if (pkt_session == '0 || pkt_previous == '0 || pkt_next <= pkt_previous)
                st = ST_TRANSITION;
            else st = ST_OK;
            verdict.accepted       = (st == ST_OK);
            verdict.status         = st;
            verdict.session_id     = (st == ST_OK) ? pkt_session  : '0;
            verdict.previous_epoch = (st == ST_OK) ? pkt_previous : '0;
            verdict.next_epoch     = (st == ST_OK) ? pkt_next     : '0;
            pending_verdicts = {pending_verdicts, verdict};
            clear_packet();
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Each verdict taken from the block is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            verdicts_seen++;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected verdict, expected none actual status %0d",
                         $time, out_if.status);
                error_count++;
            end else begin
                want = pending_verdicts.pop_front();
                check_field("accepted", want.accepted, out_if.accepted);
                check_field("status", want.status, out_if.status);
                check_field("session_id", want.session_id, out_if.session_id);
                check_field("previous_epoch", want.previous_epoch, out_if.previous_epoch);
                check_field("next_epoch", want.next_epoch, out_if.next_epoch);
            end
        end
    end

    // The receiver stalls at random at the current rate.
    initial out_if.ready = 1'b0;
    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Append one byte to the packet about to be sent.
    function automatic void add_byte(input logic [7:0] b);
        pkt_bytes = {pkt_bytes, b};
    endfunction

    // Offer one byte, possibly after some idle cycles, and hold it until taken.
    // Called and returns at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.byte_value <= b;
        in_if.last_byte  <= last;
        do @(posedge i_clk); while (!in_if.ready);
        bytes_sent++;
        track_byte(b, last);
        @(negedge i_clk);
    endtask

    task automatic send_packet();
        int i;
        for (i = 0; i < pkt_bytes.size(); i++)
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    endtask

    // Lay out a full-size packet with the given header fields.
    task automatic compose(input logic [31:0] magic, input logic [15:0] version,
                           input logic [15:0] length, input logic [63:0] session,
                           input logic [63:0] previous, input logic [63:0] next_ep);
        int i;
        pkt_bytes.delete();
        for (i = 0; i < 4; i++) add_byte(magic[8*i +: 8]);
        for (i = 0; i < 2; i++) add_byte(version[8*i +: 8]);
        for (i = 0; i < 2; i++) add_byte(length[8*i +: 8]);
        for (i = 0; i < 8; i++) add_byte(session[8*i +: 8]);
        for (i = 0; i < 8; i++) add_byte(previous[8*i +: 8]);
        for (i = 0; i < 8; i++) add_byte(next_ep[8*i +: 8]);
        for (i = 32; i < PKT_LEN; i++) add_byte(8'h00);
    endtask

    // Stop sending and wait until every verdict is in and the pipeline is empty.
    task automatic drain();
        in_if.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // The magic register is only written while the block is idle.
    task automatic write_magic(input logic [31:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        magic_reg = value;
    endtask

    // The reset magic must be in place without any write.
    task automatic test_default_magic();
        compose(MAGIC_RESET, VERSION_ONE, PKT_LEN, 64'd1, 64'd1, 64'd2);
        send_packet();
        compose(MAGIC_RESET ^ 32'h8000_0000, VERSION_ONE, PKT_LEN, 64'd1, 64'd1, 64'd2);
        send_packet();
    endtask

    // Each field check on its own, with the field extremes.
    task automatic test_field_checks();
        logic [63:0] ones;
        ones = '1;
        compose(magic_reg, VERSION_ONE, PKT_LEN, ones, ones - 64'd1, ones);
        send_packet();
        // Version one written in the wrong byte order.
        compose(magic_reg, 16'h0100, PKT_LEN, 64'd5, 64'd6, 64'd7);
        send_packet();
        compose(magic_reg, VERSION_ONE, PKT_LEN - 1, 64'd5, 64'd6, 64'd7);
        send_packet();
        // Transition cases: zero session, zero previous epoch, equal and lower
        // next epoch.
        compose(magic_reg, VERSION_ONE, PKT_LEN, 64'd0, 64'd6, 64'd7);
        send_packet();
        compose(magic_reg, VERSION_ONE, PKT_LEN, 64'd5, 64'd0, 64'd7);
        send_packet();
        compose(magic_reg, VERSION_ONE, PKT_LEN, 64'd5, ones, ones);
        send_packet();
        compose(magic_reg, VERSION_ONE, PKT_LEN, 64'd5, 64'h8000_0000_0000_0000,
                64'h7FFF_FFFF_FFFF_FFFF);
        send_packet();
    endtask

    // With several failures only the first in check order is reported.
    task automatic test_check_order();
        compose(~magic_reg, 16'd2, PKT_LEN, 64'd0, 64'd0, 64'd0);
        void'(pkt_bytes.pop_back());
        send_packet();
        compose(~magic_reg, 16'd2, 16'd0, 64'd0, 64'd0, 64'd0);
        send_packet();
        compose(magic_reg, 16'd2, 16'd0, 64'd0, 64'd0, 64'd0);
        send_packet();
        compose(magic_reg, VERSION_ONE, 16'd0, 64'd0, 64'd0, 64'd0);
        send_packet();
    endtask

    // Short and long packets, down to a single byte.
    task automatic test_packet_size();
        compose(magic_reg, VERSION_ONE, PKT_LEN, 64'd9, 64'd10, 64'd11);
        pkt_bytes = pkt_bytes[0:0];
        send_packet();
        compose(magic_reg, VERSION_ONE, PKT_LEN, 64'd9, 64'd10, 64'd11);
        pkt_bytes = pkt_bytes[0:3];
        send_packet();
        compose(magic_reg, VERSION_ONE, PKT_LEN, 64'd9, 64'd10, 64'd11);
        void'(pkt_bytes.pop_back());
        send_packet();
        compose(magic_reg, VERSION_ONE, PKT_LEN, 64'd9, 64'd10, 64'd11);
        add_byte(8'hFF);
        send_packet();
        // A good packet right after the long one shows the state starts over.
        compose(magic_reg, VERSION_ONE, PKT_LEN, 64'd9, 64'd10, 64'd11);
        send_packet();
    endtask

    // Several magic settings, the extremes among them, each with a good packet
    // and one off by a single bit.
    task automatic test_magic_settings();
        logic [31:0] settings[3];
        int          k;
        settings[0] = 32'h0000_0000;
        settings[1] = 32'hFFFF_FFFF;
        settings[2] = $urandom;
        for (k = 0; k < 3; k++) begin
            write_magic(settings[k]);
            compose(magic_reg, VERSION_ONE, PKT_LEN, rand_word(), 64'd100, 64'd101);
            send_packet();
            compose(magic_reg ^ (32'd1 << $urandom_range(31)), VERSION_ONE, PKT_LEN,
                    64'd1, 64'd2, 64'd3);
            send_packet();
        end
    endtask

    // One random packet: mostly well formed with random content, the rest
    // corrupted, cut short, too long or plain noise.
    task automatic random_packet();
        logic [63:0] session;
        logic [63:0] previous;
        logic [63:0] next_ep;
        int          kind;
        int          n;
        int          i;
        kind     = $urandom_range(99);
        session  = ($urandom_range(7) == 0) ? 64'd0 : rand_word();
        previous = ($urandom_range(7) == 0) ? 64'd0 : rand_word();
        if ($urandom_range(3) != 0) next_ep = previous + $urandom_range(1000) + 1;
        else next_ep = rand_word();
        compose(magic_reg, VERSION_ONE, PKT_LEN, session, previous, next_ep);
        if (kind < 60) begin
        end else if (kind < 75) begin
            // One flipped bit somewhere in the magic, version or length.
            n = $urandom_range(7);
            pkt_bytes[n] = pkt_bytes[n] ^ (8'd1 << $urandom_range(7));
        end else if (kind < 85) begin
            n = $urandom_range(PKT_LEN - 1, 1);
            while (pkt_bytes.size() > n) void'(pkt_bytes.pop_back());
        end else if (kind < 90) begin
            n = $urandom_range(8, 1);
            for (i = 0; i < n; i++) add_byte(8'($urandom_range(255)));
        end else begin
            pkt_bytes.delete();
            n = $urandom_range(PKT_LEN + 8, 1);
            for (i = 0; i < n; i++) add_byte(8'($urandom_range(255)));
        end
        send_packet();
    endtask

    // Random traffic under one idling setting, with a fresh magic, until enough
    // bytes and verdicts have gone through.
    task automatic test_random_traffic(input int unsigned src_pct, input int unsigned snk_pct,
                                       input logic [31:0] magic);
        int unsigned bytes_start;
        int unsigned verdicts_start;
        int          n;
        write_magic(magic);
        src_idle_pct   = src_pct;
        snk_idle_pct   = snk_pct;
        bytes_start    = bytes_sent;
        verdicts_start = verdicts_seen;
        n = 0;
        while (bytes_sent - bytes_start < 30 || verdicts_seen - verdicts_start < 1) begin
            random_packet();
            n++;
            // Now and then the sender holds off until every verdict is back.
            if (n == 1 || $urandom_range(9) == 0) drain();
        end
    endtask

    initial begin
        error_count      = 0;
        bytes_sent       = 0;
        verdicts_seen    = 0;
        src_idle_pct     = 19;
        snk_idle_pct     = 66;
        magic_reg        = MAGIC_RESET;
        clear_packet();
        in_if.valid      = 1'b0;
        in_if.byte_value = '0;
        in_if.last_byte  = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        i_rst_n          = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_magic();
        test_field_checks();
        test_check_order();
        test_packet_size();
        test_magic_settings();
        test_random_traffic(19, 66, $urandom);
        test_random_traffic(66, 19, 32'hFFFF_FFFF);
        test_random_traffic(0, 0, $urandom);
        drain();

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
